// ===== rtl/core/geht_pkg.sv =====
// Shared types and constants of the gamma energy histogram tally.
package geht_pkg;

    // Operation codes of an input word
    localparam logic [1:0] OP_RECORD  = 2'd0;
    localparam logic [1:0] OP_RD_BIN  = 2'd1;
    localparam logic [1:0] OP_RD_SUM  = 2'd2;

    // Volume codes
    localparam logic [1:0] VOL_ORIGIN  = 2'd0;
    localparam logic [1:0] VOL_CHAMBER = 2'd1;

    // Configuration register indexes
    localparam logic [3:0] REG_HIST_BASE = 4'd0;
    localparam logic [3:0] REG_SUM_BASE  = 4'd1;

    localparam logic [7:0] HIST_BASE_RESET = 8'd24;
    localparam logic [7:0] SUM_BASE_RESET  = 8'd12;

    // Field widths
    localparam int ENERGY_W = 32;
    localparam int COUNT_W  = 32;
    localparam int SUM_W    = 48;
    localparam int CFG_W    = 8;

    // floor(x / 10000) == (x * DIV_MAGIC) >> DIV_SHIFT for any 32-bit x
    localparam logic [31:0] DIV_MAGIC = 32'hD1B7_1759;
    localparam int          DIV_SHIFT = 45;
    localparam int          BIN_Q_W   = 64 - DIV_SHIFT;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Bin of a recorded energy, valid from the cycle after load
    typedef struct packed {
        logic               ok;
        logic [BIN_Q_W-1:0] bin;
    } t_bin_info;

endpackage

// ===== rtl/core/geht_bin_calc.sv =====
// Energy to histogram bin: (E-1)/10000 by reciprocal multiply, plus range check.
module geht_bin_calc #(
    parameter int NUM_BINS = 2048
) (
    input  logic                               i_clk,
    input  logic                               i_load,
    input  logic [geht_pkg::ENERGY_W-1:0]      i_energy_ev,
    output geht_pkg::t_bin_info                o_bin
);

    logic [63:0] r_prod;
    logic        r_nz;
    logic [31:0] em1;

    assign em1 = i_energy_ev - 32'd1;

    // one 32x32 product, registered
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= 64'(em1) * 64'(geht_pkg::DIV_MAGIC);
            r_nz   <= (i_energy_ev != '0);
        end
    end

    // zero energy and energies past the last bin fall in no bin
    always_comb begin
        o_bin.bin = r_prod[63:geht_pkg::DIV_SHIFT];
        o_bin.ok  = r_nz && (32'(o_bin.bin) < 32'(NUM_BINS));
    end

endmodule

// ===== rtl/core/gamma_energy_histogram_tally.sv =====
// Top level: gamma energy histogram tally with bin memory and energy sums.
//
//  channel  | direction | handshake                 | words
//  ---------+-----------+---------------------------+---------------------------------
//  in       | input     | i_in_valid / o_in_stall   | op, gamma flag, volume, copy,
//           |           |                           | energy, table, bin
//  out      | output    | o_out_valid / i_out_stall | value, valid_res
//  cfg      | input     | i_cfg_we (no wait)        | index, 8-bit data
//
// An item is registered with its bin product on acceptance; the address
// state reads the bin memory and the update state writes it back on the edge
// that may accept the next item. A result waits in the output register; a
// stalled output holds the item in its update cycle. After reset, a clearing
// pass zeroes (NUM_CHAMBERS+1)*NUM_BINS entries (26624 at the defaults), one a cycle.
module gamma_energy_histogram_tally #(
    parameter int NUM_BINS     = 2048,
    parameter int NUM_CHAMBERS = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_op,
    input  logic                            i_is_gamma,
    input  logic [1:0]                      i_volume_kind,
    input  logic [7:0]                      i_copy_number,
    input  logic [geht_pkg::ENERGY_W-1:0]   i_energy_ev,
    input  logic [3:0]                      i_table_index,
    input  logic [10:0]                     i_bin_index,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [geht_pkg::SUM_W-1:0]      o_value,
    output logic                            o_valid_res,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [3:0]                      i_cfg_index,
    input  logic [geht_pkg::CFG_W-1:0]      i_cfg_data
);

    localparam int DEPTH = (NUM_CHAMBERS + 1) * NUM_BINS;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = (NUM_CHAMBERS > 1) ? $clog2(NUM_CHAMBERS) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ADDR = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    // configuration registers
    logic [7:0] r_hist_base;
    logic [7:0] r_sum_base;

    // control
    logic [1:0]    r_st;
    logic [1:0]    n_st;
    logic          r_clr;
    logic [AW-1:0] r_clr_addr;
    logic          in_acc;
    logic          upd_go;

    // accepted item
    logic [1:0]                    r_op;
    logic                          r_gam;
    logic [1:0]                    r_vol;
    logic [7:0]                    r_copy;
    logic [geht_pkg::ENERGY_W-1:0] r_e;
    logic [3:0]                    r_tab;
    logic [10:0]                   r_bin;
    geht_pkg::t_bin_info           bin_info;

    // address stage results
    logic          n_do_cnt, n_do_sum, n_rd_cnt, n_rd_sum;
    logic [AW-1:0] n_cnt_addr;
    logic [SW-1:0] n_sidx;
    logic          r_do_cnt, r_do_sum, r_rd_cnt, r_rd_sum;
    logic [AW-1:0] r_cnt_addr;
    logic [SW-1:0] r_sidx;

    // storage
    logic [geht_pkg::COUNT_W-1:0] r_mem [DEPTH];
    logic [geht_pkg::COUNT_W-1:0] r_cnt_rd;
    logic [geht_pkg::SUM_W-1:0]   r_sums [NUM_CHAMBERS];
    logic [geht_pkg::SUM_W-1:0]   r_sum_rd;

    // update stage
    logic [geht_pkg::COUNT_W-1:0] n_cnt;
    logic [geht_pkg::SUM_W:0]     sum_wide;
    logic [geht_pkg::SUM_W-1:0]   n_sum;

    // output register
    logic                         r_out_valid;
    logic [geht_pkg::SUM_W-1:0]   r_value;
    logic                         r_valid_res;

    // handshake
    assign upd_go     = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_clr || (r_st == ST_ADDR) || ((r_st == ST_UPD) && !upd_go);
    assign in_acc     = i_in_valid && !o_in_stall;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_base <= geht_pkg::HIST_BASE_RESET;
            r_sum_base  <= geht_pkg::SUM_BASE_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == geht_pkg::REG_HIST_BASE) begin
                r_hist_base <= i_cfg_data;
            end else if (i_cfg_index == geht_pkg::REG_SUM_BASE) begin
                r_sum_base <= i_cfg_data;
            end
        end
    end

    // sequencer
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE: begin
                if (in_acc) n_st = ST_ADDR;
            end
            ST_ADDR: begin
                n_st = ST_UPD;
            end
            ST_UPD: begin
                if (upd_go) n_st = in_acc ? ST_ADDR : ST_IDLE;
            end
            default: begin
                n_st = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= ST_IDLE;
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_st <= n_st;
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) r_clr <= 1'b0;
            end
        end
    end

    // capture the accepted word
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op   <= i_op;
            r_gam  <= i_is_gamma;
            r_vol  <= i_volume_kind;
            r_copy <= i_copy_number;
            r_e    <= i_energy_ev;
            r_tab  <= i_table_index;
            r_bin  <= i_bin_index;
        end
    end

    geht_bin_calc #(
        .NUM_BINS (NUM_BINS)
    ) u_bin_calc (
        .i_clk       (i_clk),
        .i_load      (in_acc),
        .i_energy_ev (i_energy_ev),
        .o_bin       (bin_info)
    );

    // address stage: decode the operation and form the memory address
    always_comb begin
        logic [7:0]  s_h;
        logic [7:0]  s_s;
        logic        is_rec;
        logic [31:0] tab32;
        logic [31:0] bin32;
        s_h      = r_copy - r_hist_base;
        s_s      = r_copy - r_sum_base;
        is_rec   = (r_op == geht_pkg::OP_RECORD) && r_gam;
        n_do_cnt = 1'b0;
        n_do_sum = 1'b0;
        n_rd_cnt = 1'b0;
        n_rd_sum = 1'b0;
        tab32    = 32'(r_tab);
        bin32    = 32'(r_bin);
        n_sidx   = SW'(r_tab - 4'd1);
        if (is_rec) begin
            bin32 = 32'(bin_info.bin);
            if (r_vol == geht_pkg::VOL_ORIGIN) begin
                tab32    = 32'd0;
                n_do_cnt = bin_info.ok;
            end else if (r_vol == geht_pkg::VOL_CHAMBER) begin
                if (r_copy >= r_hist_base) begin
                    tab32    = 32'(s_h) + 32'd1;
                    n_do_cnt = bin_info.ok && (32'(s_h) < 32'(NUM_CHAMBERS));
                end else if (r_copy >= r_sum_base) begin
                    n_sidx   = SW'(s_s);
                    n_do_sum = (32'(s_s) < 32'(NUM_CHAMBERS));
                end
            end
        end else if (r_op == geht_pkg::OP_RD_BIN) begin
            n_rd_cnt = (bin32 < 32'(NUM_BINS))
                    && ((r_tab == '0) || (32'(r_tab) <= 32'(NUM_CHAMBERS)));
        end else if (r_op == geht_pkg::OP_RD_SUM) begin
            n_rd_sum = (r_tab != '0) && (32'(r_tab) <= 32'(NUM_CHAMBERS));
        end
        n_cnt_addr = AW'(tab32 * 32'(NUM_BINS) + bin32);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_do_cnt <= 1'b0;
            r_do_sum <= 1'b0;
            r_rd_cnt <= 1'b0;
            r_rd_sum <= 1'b0;
        end else if (r_st == ST_ADDR) begin
            r_do_cnt <= n_do_cnt;
            r_do_sum <= n_do_sum;
            r_rd_cnt <= n_rd_cnt;
            r_rd_sum <= n_rd_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == ST_ADDR) begin
            r_cnt_addr <= n_cnt_addr;
            r_sidx     <= n_sidx;
            r_sum_rd   <= r_sums[n_sidx];
        end
    end

    // bin memory: registered read in the address cycle, write back on update
    always_ff @(posedge i_clk) begin
        if (r_st == ST_ADDR) r_cnt_rd <= r_mem[n_cnt_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            r_mem[r_clr_addr] <= '0;
        end else if ((r_st == ST_UPD) && upd_go && r_do_cnt) begin
            r_mem[r_cnt_addr] <= n_cnt;
        end
    end

    // saturating update of counter and sum
    always_comb begin
        n_cnt    = (r_cnt_rd == geht_pkg::COUNT_MAX) ? r_cnt_rd : r_cnt_rd + 32'd1;
        sum_wide = {1'b0, r_sum_rd} + (geht_pkg::SUM_W + 1)'(r_e);
        n_sum    = sum_wide[geht_pkg::SUM_W] ? '1 : sum_wide[geht_pkg::SUM_W-1:0];
    end

    // energy sums in flip-flops, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CHAMBERS; k++) r_sums[k] <= '0;
        end else if ((r_st == ST_UPD) && upd_go && r_do_sum) begin
            r_sums[r_sidx] <= n_sum;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_st == ST_UPD) && upd_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_st == ST_UPD) && upd_go) begin
            r_valid_res <= r_rd_cnt || r_rd_sum;
            if (r_rd_cnt) begin
                r_value <= geht_pkg::SUM_W'(r_cnt_rd);
            end else if (r_rd_sum) begin
                r_value <= r_sum_rd;
            end else begin
                r_value <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_valid_res = r_valid_res;

    // checks
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr |-> !in_acc)
        else $error("item accepted during clearing pass");

    a_addr_then_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_ADDR) |=> (r_st == ST_UPD))
        else $error("address cycle not followed by update");

    a_upd_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_st == ST_UPD) && upd_go) |=> o_out_valid)
        else $error("completed item produced no output word");

    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_UPD) |-> $countones({r_do_cnt, r_do_sum, r_rd_cnt, r_rd_sum}) <= 1)
        else $error("more than one action decoded for an item");

endmodule

// ===== dv/geht_tally_check.sv =====
`timescale 1ns / 100ps
// Result checker for the tally: mirrors the bin and sum stores and compares each output word.
module geht_tally_check #(
    parameter int NUM_BINS     = 2048,
    parameter int NUM_CHAMBERS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [1:0]                    i_op,
    input  logic                          i_is_gamma,
    input  logic [1:0]                    i_volume_kind,
    input  logic [7:0]                    i_copy_number,
    input  logic [geht_pkg::ENERGY_W-1:0] i_energy_ev,
    input  logic [3:0]                    i_table_index,
    input  logic [10:0]                   i_bin_index,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [geht_pkg::SUM_W-1:0]    i_value,
    input  logic                          i_valid_res,
    input  logic                          i_cfg_we,
    input  logic [3:0]                    i_cfg_index,
    input  logic [geht_pkg::CFG_W-1:0]    i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_checked
);

    localparam int BIN_EV = 10000;
    localparam logic [geht_pkg::SUM_W-1:0] SUM_MAX = '1;

    typedef struct packed {
        logic [geht_pkg::SUM_W-1:0] value;
        logic                       ok;
    } t_read_word;

    // Mirrored configuration and stores
    logic [geht_pkg::CFG_W-1:0]   hist_base;
    logic [geht_pkg::CFG_W-1:0]   sum_base;
    logic [geht_pkg::COUNT_W-1:0] origin_bins  [NUM_BINS];
    logic [geht_pkg::COUNT_W-1:0] chamber_bins [NUM_CHAMBERS*NUM_BINS];
    logic [geht_pkg::SUM_W-1:0]   chamber_sums [NUM_CHAMBERS];

    t_read_word expected_words [$];
    t_read_word oldest;

    // Apply one accepted word to the mirrored stores and return its result
    function automatic t_read_word tally_word(
        input logic [1:0]                    op,
        input logic                          gam,
        input logic [1:0]                    vol,
        input logic [7:0]                    cp,
        input logic [geht_pkg::ENERGY_W-1:0] en,
        input logic [3:0]                    tab,
        input logic [10:0]                   bin
    );
        t_read_word                 r;
        logic [31:0]                bin_no;
        logic                       bin_ok;
        int                         slot;
        int                         idx;
        logic [geht_pkg::SUM_W:0]   acc;
        r      = '0;
        bin_ok = 1'b0;
        bin_no = '0;
        // bin b holds (b*10000, (b+1)*10000]
        if (en != '0) begin
            bin_no = (en - 32'd1) / BIN_EV;
            bin_ok = (bin_no < NUM_BINS);
        end
        case (op)
            geht_pkg::OP_RECORD: begin
                if (gam) begin
                    if (vol == geht_pkg::VOL_ORIGIN) begin
                        if (bin_ok && origin_bins[bin_no] != geht_pkg::COUNT_MAX)
                            origin_bins[bin_no] = origin_bins[bin_no] + 32'd1;
                    end else if (vol == geht_pkg::VOL_CHAMBER) begin
                        if (cp >= hist_base) begin
                            // histogrammed chambers are never summed
                            slot = int'(cp) - int'(hist_base);
                            if (slot < NUM_CHAMBERS && bin_ok) begin
                                idx = slot * NUM_BINS + int'(bin_no);
                                if (chamber_bins[idx] != geht_pkg::COUNT_MAX)
                                    chamber_bins[idx] = chamber_bins[idx] + 32'd1;
                            end
                        end else if (cp >= sum_base) begin
                            slot = int'(cp) - int'(sum_base);
                            if (slot < NUM_CHAMBERS) begin
                                acc = {1'b0, chamber_sums[slot]} + (geht_pkg::SUM_W + 1)'(en);
                                chamber_sums[slot] = (acc > {1'b0, SUM_MAX}) ?
                                                     SUM_MAX : acc[geht_pkg::SUM_W-1:0];
                            end
                        end
                    end
                end
            end
            geht_pkg::OP_RD_BIN: begin
                if (bin < NUM_BINS) begin
                    if (tab == '0) begin
                        r.value = {{(geht_pkg::SUM_W-geht_pkg::COUNT_W){1'b0}},
                                   origin_bins[bin]};
                        r.ok    = 1'b1;
                    end else if (tab <= NUM_CHAMBERS) begin
                        idx     = (int'(tab) - 1) * NUM_BINS + int'(bin);
                        r.value = {{(geht_pkg::SUM_W-geht_pkg::COUNT_W){1'b0}},
                                   chamber_bins[idx]};
                        r.ok    = 1'b1;
                    end
                end
            end
            geht_pkg::OP_RD_SUM: begin
                // origin volume keeps no sum
                if (tab >= 1 && tab <= NUM_CHAMBERS) begin
                    r.value = chamber_sums[int'(tab) - 1];
                    r.ok    = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Watch the channels at each rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hist_base = geht_pkg::HIST_BASE_RESET;
            sum_base  = geht_pkg::SUM_BASE_RESET;
            for (int k = 0; k < NUM_BINS; k++)
                origin_bins[k] = '0;
            for (int k = 0; k < NUM_CHAMBERS*NUM_BINS; k++)
                chamber_bins[k] = '0;
            for (int k = 0; k < NUM_CHAMBERS; k++)
                chamber_sums[k] = '0;
            expected_words.delete();
        end else begin
            // output word against the oldest expectation
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: output word with none pending: value=%h valid_res=%b",
                                 $time, i_value, i_valid_res);
                end else begin
                    oldest = expected_words.pop_front();
                    o_checked++;
                    if (i_value !== oldest.value || i_valid_res !== oldest.ok) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("%0t: word %0d: expected %h/%b, got %h/%b",
                                     $time, o_checked, oldest.value, oldest.ok,
                                     i_value, i_valid_res);
                    end
                end
            end
            // accepted input word, with the configuration in force before this edge
            if (i_in_valid && !i_in_stall)
                expected_words.push_back(tally_word(i_op, i_is_gamma, i_volume_kind,
                                                    i_copy_number, i_energy_ev,
                                                    i_table_index, i_bin_index));
            if (i_cfg_we) begin
                case (i_cfg_index)
                    geht_pkg::REG_HIST_BASE: hist_base = i_cfg_data;
                    geht_pkg::REG_SUM_BASE:  sum_base  = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending = expected_words.size();
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Testbench top for the tally: clock, reset, stimulus, register phases and verdict.
module testbench;

    localparam int NUM_BINS     = 2048;
    localparam int NUM_CHAMBERS = 12;
    localparam int BIN_EV       = 10000;
    localparam int RAND_PHASES  = 6;
    localparam int PHASE_WORDS  = 285;
    // max-energy words run into one sum at the end
    localparam int SUM_WORDS    = 16;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam logic [1:0] VOL_OTHER   = 2'd2;
    localparam logic [1:0] VOL_SPARE   = 2'd3;
    localparam logic [3:0] REG_SPARE   = 4'd2;
    localparam logic [3:0] REG_TOP     = 4'd15;

    logic                          i_clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [1:0]                    op = '0;
    logic                          is_gamma = 1'b0;
    logic [1:0]                    volume_kind = '0;
    logic [7:0]                    copy_number = '0;
    logic [geht_pkg::ENERGY_W-1:0] energy_ev = '0;
    logic [3:0]                    table_index = '0;
    logic [10:0]                   bin_index = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [geht_pkg::SUM_W-1:0]    value;
    logic                          valid_res;
    logic                          cfg_we = 1'b0;
    logic [3:0]                    cfg_index = '0;
    logic [geht_pkg::CFG_W-1:0]    cfg_data = '0;

    int fail_count;
    int pending;
    int checked;
    int words_sent = 0;
    int reg_writes = 0;
    int stall_left = 0;
    bit quiet = 1'b0;

    logic [geht_pkg::CFG_W-1:0] hist_base = geht_pkg::HIST_BASE_RESET;
    logic [geht_pkg::CFG_W-1:0] sum_base  = geht_pkg::SUM_BASE_RESET;
    int hot_bins [8] = '{0, 1, 2, 3, 7, 100, 1024, 2047};

    gamma_energy_histogram_tally #(
        .NUM_BINS     (NUM_BINS),
        .NUM_CHAMBERS (NUM_CHAMBERS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_op          (op),
        .i_is_gamma    (is_gamma),
        .i_volume_kind (volume_kind),
        .i_copy_number (copy_number),
        .i_energy_ev   (energy_ev),
        .i_table_index (table_index),
        .i_bin_index   (bin_index),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_value       (value),
        .o_valid_res   (valid_res),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    geht_tally_check #(
        .NUM_BINS     (NUM_BINS),
        .NUM_CHAMBERS (NUM_CHAMBERS)
    ) u_check (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_op          (op),
        .i_is_gamma    (is_gamma),
        .i_volume_kind (volume_kind),
        .i_copy_number (copy_number),
        .i_energy_ev   (energy_ev),
        .i_table_index (table_index),
        .i_bin_index   (bin_index),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_value       (value),
        .i_valid_res   (valid_res),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Run limit
    initial begin
        #15_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Output stall in random bursts
    initial begin
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                out_stall = 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 9);
                out_stall  = 1'b1;
            end else begin
                out_stall = 1'b0;
            end
        end
    end

    // Present one word and hold it until accepted, then maybe idle
    task automatic push_word(
        input logic [1:0]                    w_op,
        input logic                          w_gam,
        input logic [1:0]                    w_vol,
        input logic [7:0]                    w_copy,
        input logic [geht_pkg::ENERGY_W-1:0] w_energy,
        input logic [3:0]                    w_tab,
        input logic [10:0]                   w_bin
    );
        op          = w_op;
        is_gamma    = w_gam;
        volume_kind = w_vol;
        copy_number = w_copy;
        energy_ev   = w_energy;
        table_index = w_tab;
        bin_index   = w_bin;
        in_valid    = 1'b1;
        do @(posedge i_clk); while (in_stall);
        @(negedge i_clk);
        words_sent++;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
    endtask

    // Random word, mostly aimed at chambers near the bases and at a few hot bins
    task automatic push_random();
        int               pick;
        int               c;
        logic [1:0]       r_op;
        logic             r_gam;
        logic [1:0]       r_vol;
        logic [7:0]       r_copy;
        logic [31:0]      r_energy;
        logic [3:0]       r_tab;
        logic [10:0]      r_bin;
        pick     = $urandom_range(0, 99);
        r_gam    = 1'($urandom);
        r_vol    = 2'($urandom);
        r_copy   = 8'($urandom);
        r_energy = $urandom;
        r_tab    = 4'($urandom);
        r_bin    = 11'($urandom);
        if (pick < 55) begin
            r_op  = geht_pkg::OP_RECORD;
            r_gam = ($urandom_range(0, 6) != 0);
            c = $urandom_range(0, 99);
            if (c < 45)      r_vol = geht_pkg::VOL_CHAMBER;
            else if (c < 80) r_vol = geht_pkg::VOL_ORIGIN;
            else if (c < 90) r_vol = VOL_OTHER;
            else             r_vol = VOL_SPARE;
            // copy near a base, one below up to a couple past the last chamber
            if ($urandom_range(0, 9) < 7) begin
                c = ($urandom_range(0, 1) ? int'(hist_base) : int'(sum_base))
                    + $urandom_range(0, NUM_CHAMBERS + 2) - 1;
                r_copy = (c < 0 || c > 255) ? 8'($urandom) : 8'(c);
            end
            c = $urandom_range(0, 99);
            if (c < 75) begin
                r_energy = 32'(hot_bins[$urandom_range(0, 7)] * BIN_EV
                               + $urandom_range(1, BIN_EV));
            end else if (c < 85) begin
                case ($urandom_range(0, 5))
                    0: r_energy = 32'd0;
                    1: r_energy = 32'd1;
                    2: r_energy = 32'(BIN_EV);
                    3: r_energy = 32'(BIN_EV + 1);
                    4: r_energy = 32'(NUM_BINS * BIN_EV);
                    default: r_energy = 32'(NUM_BINS * BIN_EV + 1);
                endcase
            end
        end else if (pick < 95) begin
            r_op = (pick < 80) ? geht_pkg::OP_RD_BIN : geht_pkg::OP_RD_SUM;
            if ($urandom_range(0, 5) != 0)
                r_tab = 4'($urandom_range(0, NUM_CHAMBERS));
            if ($urandom_range(0, 9) < 7)
                r_bin = 11'(hot_bins[$urandom_range(0, 7)]);
        end else begin
            r_op = OP_UNUSED;
        end
        push_word(r_op, r_gam, r_vol, r_copy, r_energy, r_tab, r_bin);
    endtask

    // Wait until every pending result has come
    task automatic settle();
        in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [geht_pkg::CFG_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge i_clk);
        cfg_we = 1'b0;
        reg_writes++;
        if (idx == geht_pkg::REG_HIST_BASE) hist_base = data;
        if (idx == geht_pkg::REG_SUM_BASE)  sum_base  = data;
    endtask

    // Stimulus and verdict
    initial begin
        repeat (9) @(negedge i_clk);
        rst_n = 1'b1;

        // Directed words at reset bases: bin edges, volumes, chamber ranges, reads
        push_word(geht_pkg::OP_RECORD, 1'b1, geht_pkg::VOL_ORIGIN, 8'd0, 32'd1, 4'd0, 11'd0);
        push_word(geht_pkg::OP_RECORD, 1'b1, geht_pkg::VOL_ORIGIN, 8'd0, BIN_EV, 4'd0, 11'd0);
        push_word(geht_pkg::OP_RECORD, 1'b1, geht_pkg::VOL_ORIGIN, 8'd0, BIN_EV + 1,
                  4'd0, 11'd0);
        push_word(geht_pkg::OP_RECORD, 1'b1, geht_pkg::VOL_ORIGIN, 8'd0, NUM_BINS*BIN_EV,
                  4'd0, 11'd0);
        push_word(geht_pkg::OP_RECORD, 1'b1, geht_pkg::VOL_ORIGIN, 8'd0, NUM_BINS*BIN_EV+1,
                  4'd0, 11'd0);
        push_word(geht_pkg::OP_RECORD, 1'b1, geht_pkg::VOL_ORIGIN, 8'd0, 32'd0, 4'd0, 11'd0);
        push_word(geht_pkg::OP_RECORD, 1'b1, geht_pkg::VOL_ORIGIN, 8'd0, '1, 4'd0, 11'd0);
        push_word(geht_pkg::OP_RECORD, 1'b0, geht_pkg::VOL_ORIGIN, 8'd0, 32'd5, 4'd0, 11'd0);
        push_word(geht_pkg::OP_RECORD, 1'b1, VOL_OTHER, 8'd24, 32'd5, 4'd0, 11'd0);
        push_word(geht_pkg::OP_RECORD, 1'b1, VOL_SPARE, 8'd24, 32'd5, 4'd0, 11'd0);
        push_word(geht_pkg::OP_RECORD, 1'b1, geht_pkg::VOL_CHAMBER, 8'd24, 32'd5, 4'd0, 11'd0);
        push_word(geht_pkg::OP_RECORD, 1'b1, geht_pkg::VOL_CHAMBER, 8'd35, NUM_BINS*BIN_EV,
                  4'd0, 11'd0);
        push_word(geht_pkg::OP_RECORD, 1'b1, geht_pkg::VOL_CHAMBER, 8'd36, 32'd5, 4'd0, 11'd0);
        push_word(geht_pkg::OP_RECORD, 1'b1, geht_pkg::VOL_CHAMBER, 8'd12, '1, 4'd0, 11'd0);
        push_word(geht_pkg::OP_RECORD, 1'b1, geht_pkg::VOL_CHAMBER, 8'd23, 32'd0, 4'd0, 11'd0);
        push_word(geht_pkg::OP_RECORD, 1'b1, geht_pkg::VOL_CHAMBER, 8'd11, 32'd5, 4'd0, 11'd0);
        push_word(geht_pkg::OP_RD_BIN, 1'b0, geht_pkg::VOL_ORIGIN, 8'd0, 32'd0, 4'd0, 11'd0);
        push_word(geht_pkg::OP_RD_BIN, 1'b0, geht_pkg::VOL_ORIGIN, 8'd0, 32'd0, 4'd0, 11'd2047);
        push_word(geht_pkg::OP_RD_BIN, 1'b0, geht_pkg::VOL_ORIGIN, 8'd0, 32'd0, 4'd1, 11'd0);
        push_word(geht_pkg::OP_RD_BIN, 1'b0, geht_pkg::VOL_ORIGIN, 8'd0, 32'd0, 4'd12, 11'd2047);
        push_word(geht_pkg::OP_RD_BIN, 1'b0, geht_pkg::VOL_ORIGIN, 8'd0, 32'd0, 4'd13, 11'd0);
        push_word(geht_pkg::OP_RD_SUM, 1'b0, geht_pkg::VOL_ORIGIN, 8'd0, 32'd0, 4'd0, 11'd0);
        push_word(geht_pkg::OP_RD_SUM, 1'b0, geht_pkg::VOL_ORIGIN, 8'd0, 32'd0, 4'd1, 11'd0);
        push_word(geht_pkg::OP_RD_SUM, 1'b0, geht_pkg::VOL_ORIGIN, 8'd0, 32'd0, 4'd15, 11'd0);
        push_word(OP_UNUSED, 1'b1, VOL_SPARE, '1, '1, '1, '1);

        // Random phases over several base settings; the last one runs without idling
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph > 0) begin
                settle();
                case (ph)
                    1: begin
                        write_reg(geht_pkg::REG_HIST_BASE, 8'd0);
                        write_reg(geht_pkg::REG_SUM_BASE,  8'd0);
                    end
                    2: begin
                        write_reg(geht_pkg::REG_HIST_BASE, 8'd255);
                        write_reg(geht_pkg::REG_SUM_BASE,  8'd255);
                        write_reg(REG_SPARE, 8'($urandom));
                    end
                    3: begin
                        write_reg(geht_pkg::REG_HIST_BASE, 8'd20);
                        write_reg(geht_pkg::REG_SUM_BASE,  8'd4);
                        write_reg(REG_TOP, 8'($urandom));
                    end
                    4: begin
                        write_reg(geht_pkg::REG_HIST_BASE, 8'd250);
                        write_reg(geht_pkg::REG_SUM_BASE,  8'd240);
                    end
                    default: begin
                        write_reg(geht_pkg::REG_HIST_BASE, 8'($urandom));
                        write_reg(geht_pkg::REG_SUM_BASE,  8'($urandom));
                        quiet = 1'b1;
                    end
                endcase
            end
            repeat (PHASE_WORDS) push_random();
        end

        // Run max-energy words into chamber 0's sum back to back, reading it around them
        settle();
        write_reg(geht_pkg::REG_HIST_BASE, 8'd255);
        write_reg(geht_pkg::REG_SUM_BASE,  8'd0);
        push_word(geht_pkg::OP_RD_SUM, 1'b0, geht_pkg::VOL_ORIGIN, 8'd0, 32'd0, 4'd1, 11'd0);
        repeat (SUM_WORDS)
            push_word(geht_pkg::OP_RECORD, 1'b1, geht_pkg::VOL_CHAMBER, 8'd0, '1, 4'd0, 11'd0);
        push_word(geht_pkg::OP_RD_SUM, 1'b0, geht_pkg::VOL_ORIGIN, 8'd0, 32'd0, 4'd1, 11'd0);
        push_word(geht_pkg::OP_RECORD, 1'b1, geht_pkg::VOL_CHAMBER, 8'd0, 32'd1, 4'd0, 11'd0);
        push_word(geht_pkg::OP_RD_SUM, 1'b0, geht_pkg::VOL_ORIGIN, 8'd0, 32'd0, 4'd1, 11'd0);

        // Drain, with a bound
        in_valid = 1'b0;
        for (int k = 0; k < 50000 && pending != 0; k++) @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        $display("Sent %0d words (edge energies, all volumes and ops) over %0d register writes.",
                 words_sent, reg_writes);
        $display("Compared %0d results; %0d failures, %0d still pending.",
                 checked, fail_count, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
